// ===== src/hrf_pkg.sv =====
// Shared types, register-file map and micro-program of the HLLC flux unit.
package hrf_pkg;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 6;
    localparam int PC_W   = 7;
    localparam int IN_WORDS = 10;
    localparam int OUT_WORDS = 5;

    // Register-file map. Entries 0..7 are cleared after reset; ZERO is never written again.
    localparam logic [ADDR_W-1:0] L_DEN = 6'd0;
    localparam logic [ADDR_W-1:0] L_VX  = 6'd1;
    localparam logic [ADDR_W-1:0] L_VY  = 6'd2;
    localparam logic [ADDR_W-1:0] L_VZ  = 6'd3;
    localparam logic [ADDR_W-1:0] L_E   = 6'd4;
    localparam logic [ADDR_W-1:0] L_P   = 6'd5;
    localparam logic [ADDR_W-1:0] L_C   = 6'd6;
    localparam logic [ADDR_W-1:0] ZERO  = 6'd7;
    localparam logic [ADDR_W-1:0] R_DEN = 6'd8;
    localparam logic [ADDR_W-1:0] R_VX  = 6'd9;
    localparam logic [ADDR_W-1:0] R_VY  = 6'd10;
    localparam logic [ADDR_W-1:0] R_VZ  = 6'd11;
    localparam logic [ADDR_W-1:0] R_E   = 6'd12;
    localparam logic [ADDR_W-1:0] R_P   = 6'd13;
    localparam logic [ADDR_W-1:0] R_C   = 6'd14;
    localparam logic [ADDR_W-1:0] N_X   = 6'd16;
    localparam logic [ADDR_W-1:0] N_Y   = 6'd17;
    localparam logic [ADDR_W-1:0] N_Z   = 6'd18;
    localparam logic [ADDR_W-1:0] T0    = 6'd19;
    localparam logic [ADDR_W-1:0] T1    = 6'd20;
    localparam logic [ADDR_W-1:0] VNL   = 6'd21;
    localparam logic [ADDR_W-1:0] VNR   = 6'd22;
    localparam logic [ADDR_W-1:0] WL    = 6'd23;
    localparam logic [ADDR_W-1:0] WR    = 6'd24;
    localparam logic [ADDR_W-1:0] AL    = 6'd25;
    localparam logic [ADDR_W-1:0] AR    = 6'd26;
    localparam logic [ADDR_W-1:0] NUM   = 6'd27;
    localparam logic [ADDR_W-1:0] DEN   = 6'd28;
    localparam logic [ADDR_W-1:0] SMID  = 6'd29;
    localparam logic [ADDR_W-1:0] K_DEN = 6'd32;
    localparam logic [ADDR_W-1:0] K_VX  = 6'd33;
    localparam logic [ADDR_W-1:0] K_VY  = 6'd34;
    localparam logic [ADDR_W-1:0] K_VZ  = 6'd35;
    localparam logic [ADDR_W-1:0] K_E   = 6'd36;
    localparam logic [ADDR_W-1:0] K_P   = 6'd37;
    localparam logic [ADDR_W-1:0] WS    = 6'd39;
    localparam logic [ADDR_W-1:0] KVN   = 6'd40;
    localparam logic [ADDR_W-1:0] KSQ   = 6'd41;
    localparam logic [ADDR_W-1:0] MX    = 6'd42;
    localparam logic [ADDR_W-1:0] MY    = 6'd43;
    localparam logic [ADDR_W-1:0] MZ    = 6'd44;
    localparam logic [ADDR_W-1:0] ENG   = 6'd45;
    localparam logic [ADDR_W-1:0] ETOT  = 6'd46;
    localparam logic [ADDR_W-1:0] F0    = 6'd47;
    localparam logic [ADDR_W-1:0] F1    = 6'd48;
    localparam logic [ADDR_W-1:0] F2    = 6'd49;
    localparam logic [ADDR_W-1:0] F3    = 6'd50;
    localparam logic [ADDR_W-1:0] F4    = 6'd51;
    localparam logic [ADDR_W-1:0] REL   = 6'd52;
    localparam logic [ADDR_W-1:0] DRHO  = 6'd53;
    localparam logic [ADDR_W-1:0] DVN   = 6'd54;
    localparam logic [ADDR_W-1:0] RSTAR = 6'd55;
    localparam logic [ADDR_W-1:0] ESTAR = 6'd56;

    localparam logic [PC_W-1:0] PC_LCOPY  = 7'd39;
    localparam logic [PC_W-1:0] PC_RCOPY  = 7'd48;
    localparam logic [PC_W-1:0] PC_FLUX   = 7'd56;
    localparam logic [PC_W-1:0] PC_OUTPUT = 7'd121;
    localparam logic [PC_W-1:0] PC_LAST   = 7'd126;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_HALF, OP_DIV, OP_MIN, OP_MAX,
        OP_BRN, OP_BRP, OP_BRZS, OP_JMP, OP_STAR0, OP_STAR1, OP_OUT, OP_END
    } op_t;

    typedef enum logic [1:0] {WSEL_ALU, WSEL_DIV, WSEL_IN, WSEL_ZERO} wsel_t;

    typedef struct packed {
        op_t             op;
        logic [PC_W-1:0] d;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
    } instr_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        wsel_t             wsel;
        logic [ADDR_W-1:0] ra;
        logic [ADDR_W-1:0] rb;
        op_t               op;
        logic              in_capture;
        logic [3:0]        in_idx;
        logic              div_start;
        logic              stage_we;
        logic [2:0]        stage_idx;
        logic              out_load;
    } cmd_t;

    typedef struct packed {
        logic a_neg;
        logic a_pos;
        logic div_done;
    } status_t;

    function automatic logic [DATA_W-1:0] sat64(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (x < -64'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return x[31:0];
        end
    endfunction

    function automatic instr_t alu(input op_t o, input logic [ADDR_W-1:0] dst,
                                   input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] b);
        return '{op: o, d: {1'b0, dst}, a: a, b: b};
    endfunction

    function automatic instr_t br(input op_t o, input logic [PC_W-1:0] tgt,
                                  input logic [ADDR_W-1:0] a);
        return '{op: o, d: tgt, a: a, b: ZERO};
    endfunction

    function automatic instr_t prog(input logic [PC_W-1:0] pc);
        instr_t i;
        i = br(OP_END, '0, ZERO);
        case (pc)
            7'd0:   i = alu(OP_MUL, T0, L_VX, N_X);
            7'd1:   i = alu(OP_ADD, VNL, ZERO, T0);
            7'd2:   i = alu(OP_MUL, T0, L_VY, N_Y);
            7'd3:   i = alu(OP_ADD, VNL, VNL, T0);
            7'd4:   i = alu(OP_MUL, T0, L_VZ, N_Z);
            7'd5:   i = alu(OP_ADD, VNL, VNL, T0);
            7'd6:   i = alu(OP_MUL, T0, R_VX, N_X);
            7'd7:   i = alu(OP_ADD, VNR, ZERO, T0);
            7'd8:   i = alu(OP_MUL, T0, R_VY, N_Y);
            7'd9:   i = alu(OP_ADD, VNR, VNR, T0);
            7'd10:  i = alu(OP_MUL, T0, R_VZ, N_Z);
            7'd11:  i = alu(OP_ADD, VNR, VNR, T0);
            7'd12:  i = alu(OP_SUB, WL, VNL, L_C);
            7'd13:  i = alu(OP_SUB, T0, VNR, R_C);
            7'd14:  i = alu(OP_MIN, WL, WL, T0);
            7'd15:  i = alu(OP_ADD, WR, VNL, L_C);
            7'd16:  i = alu(OP_ADD, T0, VNR, R_C);
            7'd17:  i = alu(OP_MAX, WR, WR, T0);
            7'd18:  i = alu(OP_SUB, AL, WL, VNL);
            7'd19:  i = alu(OP_SUB, AR, WR, VNR);
            7'd20:  i = alu(OP_SUB, NUM, R_P, L_P);
            7'd21:  i = alu(OP_MUL, T0, L_DEN, VNL);
            7'd22:  i = alu(OP_MUL, T0, T0, AL);
            7'd23:  i = alu(OP_ADD, NUM, NUM, T0);
            7'd24:  i = alu(OP_MUL, T0, R_DEN, VNR);
            7'd25:  i = alu(OP_MUL, T0, T0, AR);
            7'd26:  i = alu(OP_SUB, NUM, NUM, T0);
            7'd27:  i = alu(OP_MUL, T0, L_DEN, AL);
            7'd28:  i = alu(OP_MUL, T1, R_DEN, AR);
            7'd29:  i = alu(OP_SUB, DEN, T0, T1);
            7'd30:  i = alu(OP_DIV, SMID, NUM, DEN);
            7'd31:  i = br(OP_BRN, 7'd34, WL);
            7'd32:  i = br(OP_STAR0, '0, ZERO);
            7'd33:  i = br(OP_JMP, PC_LCOPY, ZERO);
            7'd34:  i = br(OP_BRP, 7'd37, WR);
            7'd35:  i = br(OP_STAR0, '0, ZERO);
            7'd36:  i = br(OP_JMP, PC_RCOPY, ZERO);
            7'd37:  i = br(OP_STAR1, '0, ZERO);
            7'd38:  i = br(OP_BRN, PC_RCOPY, SMID);
            7'd39:  i = alu(OP_ADD, K_DEN, L_DEN, ZERO);
            7'd40:  i = alu(OP_ADD, K_VX, L_VX, ZERO);
            7'd41:  i = alu(OP_ADD, K_VY, L_VY, ZERO);
            7'd42:  i = alu(OP_ADD, K_VZ, L_VZ, ZERO);
            7'd43:  i = alu(OP_ADD, K_E, L_E, ZERO);
            7'd44:  i = alu(OP_ADD, K_P, L_P, ZERO);
            7'd45:  i = alu(OP_ADD, T1, L_C, ZERO);
            7'd46:  i = alu(OP_ADD, WS, WL, ZERO);
            7'd47:  i = br(OP_JMP, PC_FLUX, ZERO);
            7'd48:  i = alu(OP_ADD, K_DEN, R_DEN, ZERO);
            7'd49:  i = alu(OP_ADD, K_VX, R_VX, ZERO);
            7'd50:  i = alu(OP_ADD, K_VY, R_VY, ZERO);
            7'd51:  i = alu(OP_ADD, K_VZ, R_VZ, ZERO);
            7'd52:  i = alu(OP_ADD, K_E, R_E, ZERO);
            7'd53:  i = alu(OP_ADD, K_P, R_P, ZERO);
            7'd54:  i = alu(OP_ADD, T1, R_C, ZERO);
            7'd55:  i = alu(OP_ADD, WS, WR, ZERO);
            7'd56:  i = alu(OP_MUL, T0, K_VX, N_X);
            7'd57:  i = alu(OP_ADD, KVN, ZERO, T0);
            7'd58:  i = alu(OP_MUL, T0, K_VY, N_Y);
            7'd59:  i = alu(OP_ADD, KVN, KVN, T0);
            7'd60:  i = alu(OP_MUL, T0, K_VZ, N_Z);
            7'd61:  i = alu(OP_ADD, KVN, KVN, T0);
            7'd62:  i = alu(OP_MUL, T0, K_VX, K_VX);
            7'd63:  i = alu(OP_ADD, KSQ, ZERO, T0);
            7'd64:  i = alu(OP_MUL, T0, K_VY, K_VY);
            7'd65:  i = alu(OP_ADD, KSQ, KSQ, T0);
            7'd66:  i = alu(OP_MUL, T0, K_VZ, K_VZ);
            7'd67:  i = alu(OP_ADD, KSQ, KSQ, T0);
            7'd68:  i = alu(OP_MUL, MX, K_DEN, K_VX);
            7'd69:  i = alu(OP_MUL, MY, K_DEN, K_VY);
            7'd70:  i = alu(OP_MUL, MZ, K_DEN, K_VZ);
            7'd71:  i = alu(OP_HALF, T0, KSQ, ZERO);
            7'd72:  i = alu(OP_ADD, ENG, K_E, T0);
            7'd73:  i = alu(OP_MUL, ETOT, K_DEN, ENG);
            7'd74:  i = alu(OP_MUL, F0, K_DEN, KVN);
            7'd75:  i = alu(OP_MUL, T0, KVN, MX);
            7'd76:  i = alu(OP_MUL, T1, K_P, N_X);
            7'd77:  i = alu(OP_ADD, F1, T0, T1);
            7'd78:  i = alu(OP_MUL, T0, KVN, MY);
            7'd79:  i = alu(OP_MUL, T1, K_P, N_Y);
            7'd80:  i = alu(OP_ADD, F2, T0, T1);
            7'd81:  i = alu(OP_MUL, T0, KVN, MZ);
            7'd82:  i = alu(OP_MUL, T1, K_P, N_Z);
            7'd83:  i = alu(OP_ADD, F3, T0, T1);
            7'd84:  i = alu(OP_ADD, T0, ETOT, K_P);
            7'd85:  i = alu(OP_MUL, F4, KVN, T0);
            7'd86:  i = br(OP_BRZS, PC_OUTPUT, ZERO);
            7'd87:  i = alu(OP_SUB, REL, WS, KVN);
            7'd88:  i = alu(OP_MUL, DRHO, K_DEN, REL);
            7'd89:  i = alu(OP_SUB, DVN, SMID, KVN);
            7'd90:  i = alu(OP_SUB, T0, WS, SMID);
            7'd91:  i = alu(OP_DIV, RSTAR, DRHO, T0);
            7'd92:  i = alu(OP_DIV, T0, K_P, DRHO);
            7'd93:  i = alu(OP_ADD, T0, SMID, T0);
            7'd94:  i = alu(OP_MUL, T0, DVN, T0);
            7'd95:  i = alu(OP_ADD, T0, ENG, T0);
            7'd96:  i = alu(OP_MUL, ESTAR, RSTAR, T0);
            7'd97:  i = alu(OP_SUB, T0, RSTAR, K_DEN);
            7'd98:  i = alu(OP_MUL, T0, WS, T0);
            7'd99:  i = alu(OP_ADD, F0, F0, T0);
            7'd100: i = alu(OP_MUL, T0, N_X, DVN);
            7'd101: i = alu(OP_ADD, T0, K_VX, T0);
            7'd102: i = alu(OP_MUL, T0, RSTAR, T0);
            7'd103: i = alu(OP_SUB, T0, T0, MX);
            7'd104: i = alu(OP_MUL, T0, WS, T0);
            7'd105: i = alu(OP_ADD, F1, F1, T0);
            7'd106: i = alu(OP_MUL, T0, N_Y, DVN);
            7'd107: i = alu(OP_ADD, T0, K_VY, T0);
            7'd108: i = alu(OP_MUL, T0, RSTAR, T0);
            7'd109: i = alu(OP_SUB, T0, T0, MY);
            7'd110: i = alu(OP_MUL, T0, WS, T0);
            7'd111: i = alu(OP_ADD, F2, F2, T0);
            7'd112: i = alu(OP_MUL, T0, N_Z, DVN);
            7'd113: i = alu(OP_ADD, T0, K_VZ, T0);
            7'd114: i = alu(OP_MUL, T0, RSTAR, T0);
            7'd115: i = alu(OP_SUB, T0, T0, MZ);
            7'd116: i = alu(OP_MUL, T0, WS, T0);
            7'd117: i = alu(OP_ADD, F3, F3, T0);
            7'd118: i = alu(OP_SUB, T0, ESTAR, ETOT);
            7'd119: i = alu(OP_MUL, T0, WS, T0);
            7'd120: i = alu(OP_ADD, F4, F4, T0);
            7'd121: i = alu(OP_OUT, 6'd0, F0, ZERO);
            7'd122: i = alu(OP_OUT, 6'd1, F1, ZERO);
            7'd123: i = alu(OP_OUT, 6'd2, F2, ZERO);
            7'd124: i = alu(OP_OUT, 6'd3, F3, ZERO);
            7'd125: i = alu(OP_OUT, 6'd4, F4, ZERO);
            default: i = br(OP_END, '0, ZERO);
        endcase
        return i;
    endfunction

endpackage

// ===== src/hrf_ram.sv =====
// Generic register-file RAM with one write port and two registered read ports.
module hrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

// ===== src/hrf_div.sv =====
// Radix-2 restoring divider computing saturated (a * 2^FRAC_BITS) / b, truncated toward zero.
module hrf_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        busy,
    output logic        done,
    output logic [31:0] result
);
    localparam int QW = 32 + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0] quo_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   dvs_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [31:0] a_mag;
    logic [31:0] b_mag;
    logic [31:0] b_grd;
    logic [32:0] rem_sh;
    logic        fits;

    always_comb begin
        // A zero divisor is replaced by one LSB.
        b_grd  = (b == '0) ? 32'd1 : b;
        a_mag  = a[31] ? (~a + 32'd1) : a;
        b_mag  = b_grd[31] ? (~b_grd + 32'd1) : b_grd;
        rem_sh = {rem_reg, quo_reg[QW-1]};
        fits   = rem_sh >= {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= {a_mag, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            dvs_reg <= b_mag;
            neg_reg <= a[31] ^ b_grd[31];
        end else if (busy_reg) begin
            // The dividend shifts out of the top while quotient bits enter at the bottom.
            quo_reg <= {quo_reg[QW-2:0], fits};
            rem_reg <= fits ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
        end
    end

    localparam logic [QW-1:0] MAG_MIN = {{(QW-32){1'b0}}, 32'h8000_0000};
    localparam logic [QW-1:0] MAG_MAX = {{(QW-32){1'b0}}, 32'h7fff_ffff};

    always_comb begin
        if (neg_reg) begin
            result = (quo_reg > MAG_MIN) ? 32'h8000_0000 : (~quo_reg[31:0] + 32'd1);
        end else begin
            result = (quo_reg > MAG_MAX) ? 32'h7fff_ffff : quo_reg[31:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("divider started while busy");
    a_done_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) |-> done_reg) else $error("divider finished without done");
endmodule

// ===== src/hrf_datapath.sv =====
// Datapath: input buffer, register file, saturating ALU, divider and output registers.
module hrf_datapath #(
    parameter int DIM = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  hrf_pkg::cmd_t       cmd,
    output hrf_pkg::status_t    status,
    input  logic signed [31:0]  s_density,
    input  logic signed [31:0]  s_vel_x,
    input  logic signed [31:0]  s_vel_y,
    input  logic signed [31:0]  s_vel_z,
    input  logic signed [31:0]  s_internal_energy,
    input  logic signed [31:0]  s_pressure,
    input  logic signed [31:0]  s_sound_speed,
    input  logic signed [31:0]  s_normal_x,
    input  logic signed [31:0]  s_normal_y,
    input  logic signed [31:0]  s_normal_z,
    output logic signed [31:0]  m_mass_flux,
    output logic signed [31:0]  m_mom_flux_x,
    output logic signed [31:0]  m_mom_flux_y,
    output logic signed [31:0]  m_mom_flux_z,
    output logic signed [31:0]  m_energy_flux
);
    import hrf_pkg::*;

    logic [DATA_W-1:0] inbuf_reg [IN_WORDS];
    logic [DATA_W-1:0] stage_reg [OUT_WORDS];
    logic [DATA_W-1:0] out_reg   [OUT_WORDS];
    logic [DATA_W-1:0] rdata_a;
    logic [DATA_W-1:0] rdata_b;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] alu_res;
    logic [DATA_W-1:0] div_res;
    logic              div_busy;
    logic              div_done;
    logic signed [DATA_W-1:0] op_a;
    logic signed [DATA_W-1:0] op_b;
    logic signed [63:0] prod;
    logic signed [63:0] prod_sh;

    // Components beyond DIM are forced to zero so they drop out of every sum.
    always_ff @(posedge aclk) begin
        if (cmd.in_capture) begin
            inbuf_reg[0] <= s_density;
            inbuf_reg[1] <= s_vel_x;
            inbuf_reg[2] <= (DIM > 1) ? s_vel_y : '0;
            inbuf_reg[3] <= (DIM > 2) ? s_vel_z : '0;
            inbuf_reg[4] <= s_internal_energy;
            inbuf_reg[5] <= s_pressure;
            inbuf_reg[6] <= s_sound_speed;
            inbuf_reg[7] <= s_normal_x;
            inbuf_reg[8] <= (DIM > 1) ? s_normal_y : '0;
            inbuf_reg[9] <= (DIM > 2) ? s_normal_z : '0;
        end
    end

    assign op_a    = signed'(rdata_a);
    assign op_b    = signed'(rdata_b);
    assign prod    = 64'(op_a) * 64'(op_b);
    assign prod_sh = prod >>> FRAC_BITS;

    always_comb begin
        case (cmd.op)
            OP_ADD:  alu_res = sat64(64'(op_a) + 64'(op_b));
            OP_SUB:  alu_res = sat64(64'(op_a) - 64'(op_b));
            OP_MUL:  alu_res = sat64(prod_sh);
            OP_HALF: alu_res = 32'(op_a >>> 1);
            OP_MIN:  alu_res = (op_b < op_a) ? rdata_b : rdata_a;
            OP_MAX:  alu_res = (op_b > op_a) ? rdata_b : rdata_a;
            default: alu_res = rdata_a;
        endcase
    end

    always_comb begin
        case (cmd.wsel)
            WSEL_ALU: wdata = alu_res;
            WSEL_DIV: wdata = div_res;
            WSEL_IN:  wdata = inbuf_reg[cmd.in_idx];
            default:  wdata = '0;
        endcase
    end

    hrf_ram #(.WIDTH(DATA_W), .DEPTH(64)) u_rf (
        .aclk    (aclk),
        .we      (cmd.we),
        .waddr   (cmd.waddr),
        .wdata   (wdata),
        .raddr_a (cmd.ra),
        .raddr_b (cmd.rb),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    hrf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .a       (rdata_a),
        .b       (rdata_b),
        .busy    (div_busy),
        .done    (div_done),
        .result  (div_res)
    );

    always_ff @(posedge aclk) begin
        if (cmd.stage_we) begin
            stage_reg[cmd.stage_idx] <= rdata_a;
        end
        if (cmd.out_load) begin
            for (int k = 0; k < OUT_WORDS; k++) begin
                out_reg[k] <= stage_reg[k];
            end
        end
    end

    always_comb begin
        status.a_neg    = op_a[31];
        status.a_pos    = !op_a[31] && (op_a != '0);
        status.div_done = div_done && !div_busy;
    end

    assign m_mass_flux   = signed'(out_reg[0]);
    assign m_mom_flux_x  = signed'(out_reg[1]);
    assign m_mom_flux_y  = signed'(out_reg[2]);
    assign m_mom_flux_z  = signed'(out_reg[3]);
    assign m_energy_flux = signed'(out_reg[4]);
endmodule

// ===== src/hrf_ctrl.sv =====
// Controller: reset clearing pass, input load sequencer and micro-program sequencer.
module hrf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_side,
    output logic             m_valid,
    input  logic             m_ready,
    output hrf_pkg::cmd_t    cmd,
    input  hrf_pkg::status_t status
);
    import hrf_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_LOAD, ST_READ, ST_EXEC, ST_DIVW, ST_DONE
    } state_t;

    state_t          state_reg;
    logic [PC_W-1:0] pc_reg;
    logic [3:0]      cnt_reg;
    logic            star_reg;
    logic            side_reg;
    logic            m_valid_reg;
    instr_t          inst;
    logic            out_free;
    logic [PC_W-1:0] pc_inc;

    assign inst     = prog(pc_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign pc_inc   = pc_reg + 7'd1;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd            = '0;
        cmd.ra         = inst.a;
        cmd.rb         = inst.b;
        cmd.op         = inst.op;
        cmd.wsel       = WSEL_ALU;
        cmd.waddr      = inst.d[ADDR_W-1:0];
        cmd.in_idx     = cnt_reg;
        cmd.stage_idx  = inst.d[2:0];
        case (state_reg)
            ST_CLEAR: begin
                cmd.we    = 1'b1;
                cmd.wsel  = WSEL_ZERO;
                cmd.waddr = ADDR_W'(cnt_reg);
            end
            ST_IDLE: begin
                cmd.in_capture = s_valid;
            end
            ST_LOAD: begin
                cmd.we   = 1'b1;
                cmd.wsel = WSEL_IN;
                if (!side_reg) begin
                    cmd.waddr = ADDR_W'(cnt_reg);
                end else if (cnt_reg < 4'd7) begin
                    cmd.waddr = R_DEN + ADDR_W'(cnt_reg);
                end else begin
                    cmd.waddr = N_X + ADDR_W'(cnt_reg - 4'd7);
                end
            end
            ST_EXEC: begin
                case (inst.op)
                    OP_ADD, OP_SUB, OP_MUL, OP_HALF, OP_MIN, OP_MAX: cmd.we = 1'b1;
                    OP_DIV:  cmd.div_start = 1'b1;
                    OP_OUT:  cmd.stage_we  = 1'b1;
                    default: cmd.we = 1'b0;
                endcase
            end
            ST_DIVW: begin
                cmd.we   = status.div_done;
                cmd.wsel = WSEL_DIV;
            end
            ST_DONE: begin
                cmd.out_load = out_free;
            end
            default: cmd.we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            pc_reg      <= '0;
            cnt_reg     <= '0;
            star_reg    <= 1'b0;
            side_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd7) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    cnt_reg <= '0;
                    pc_reg  <= '0;
                    if (s_valid) begin
                        side_reg  <= s_side;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (!side_reg && cnt_reg == 4'd6) begin
                        state_reg <= ST_IDLE;
                    end else if (side_reg && cnt_reg == 4'd9) begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    state_reg <= ST_READ;
                    pc_reg    <= pc_inc;
                    case (inst.op)
                        OP_DIV: begin
                            state_reg <= ST_DIVW;
                            pc_reg    <= pc_reg;
                        end
                        OP_BRN: if (status.a_neg) pc_reg <= inst.d;
                        OP_BRP: if (status.a_pos) pc_reg <= inst.d;
                        OP_BRZS: if (!star_reg) pc_reg <= inst.d;
                        OP_JMP: pc_reg <= inst.d;
                        OP_STAR0: star_reg <= 1'b0;
                        OP_STAR1: star_reg <= 1'b1;
                        OP_END: state_reg <= ST_DONE;
                        default: pc_reg <= pc_inc;
                    endcase
                end
                ST_DIVW: begin
                    if (status.div_done) begin
                        pc_reg    <= pc_inc;
                        state_reg <= ST_READ;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("output registers overwritten while holding a result");
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |-> (pc_reg <= PC_LAST))
        else $error("program counter ran past the end of the program");
endmodule

// ===== src/hllc_riemann_flux_unit.sv =====
// HLLC flux unit top level: connects the controller and the datapath.
// Sequence: a left-state transaction is taken in ST_IDLE and its words are written in ST_LOAD.
// A right state is loaded likewise; then each micro-instruction passes ST_READ and ST_EXEC, and
// each division waits in ST_DIVW (one on a supersonic face, three on a star branch).
// Throughput: one at a time; the next is taken after a left load or once the result is issued.
// Reset: synchronous, active low; a clearing pass then clears the held left state.
module hllc_riemann_flux_unit #(
    parameter int DIM = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_side,
    input  logic signed [31:0] s_density,
    input  logic signed [31:0] s_vel_x,
    input  logic signed [31:0] s_vel_y,
    input  logic signed [31:0] s_vel_z,
    input  logic signed [31:0] s_internal_energy,
    input  logic signed [31:0] s_pressure,
    input  logic signed [31:0] s_sound_speed,
    input  logic signed [31:0] s_normal_x,
    input  logic signed [31:0] s_normal_y,
    input  logic signed [31:0] s_normal_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_mass_flux,
    output logic signed [31:0] m_mom_flux_x,
    output logic signed [31:0] m_mom_flux_y,
    output logic signed [31:0] m_mom_flux_z,
    output logic signed [31:0] m_energy_flux
);
    import hrf_pkg::*;

    cmd_t    cmd;
    status_t status;

    hrf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_side  (s_side),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    hrf_datapath #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_density         (s_density),
        .s_vel_x           (s_vel_x),
        .s_vel_y           (s_vel_y),
        .s_vel_z           (s_vel_z),
        .s_internal_energy (s_internal_energy),
        .s_pressure        (s_pressure),
        .s_sound_speed     (s_sound_speed),
        .s_normal_x        (s_normal_x),
        .s_normal_y        (s_normal_y),
        .s_normal_z        (s_normal_z),
        .m_mass_flux       (m_mass_flux),
        .m_mom_flux_x      (m_mom_flux_x),
        .m_mom_flux_y      (m_mom_flux_y),
        .m_mom_flux_z      (m_mom_flux_z),
        .m_energy_flux     (m_energy_flux)
    );
endmodule

// ===== tb/sv/tb_hllc_riemann_flux_unit.sv =====
// Self-checking testbench for the HLLC flux unit with a bit-exact flux predictor.
module tb_hllc_riemann_flux_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM = 3;
    localparam int FRAC_BITS = 16;
    localparam int ONE = 1 << FRAC_BITS;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 600;

    typedef struct {
        bit side;
        int v[10];
    } face_item_t;

    typedef struct {
        int f[5];
    } flux_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_side = 1'b0;
    logic signed [31:0] s_density = '0, s_vel_x = '0, s_vel_y = '0, s_vel_z = '0;
    logic signed [31:0] s_internal_energy = '0, s_pressure = '0, s_sound_speed = '0;
    logic signed [31:0] s_normal_x = '0, s_normal_y = '0, s_normal_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_mass_flux, m_mom_flux_x, m_mom_flux_y, m_mom_flux_z, m_energy_flux;

    face_item_t pending_faces[$];
    flux_t expected_fluxes[$];
    face_item_t cur_face;
    longint left_held[7];
    int send_idle = 26;
    int recv_idle = 82;
    int fail_count = 0;
    int stall_cycles = 0;

    hllc_riemann_flux_unit #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) dut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint fx_add(longint a, longint b);
        return sat32(a + b);
    endfunction

    function automatic longint fx_sub(longint a, longint b);
        return sat32(a - b);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return sat32((a * b) >>> FRAC_BITS);
    endfunction

    // A zero divisor stands for the tiny guard and becomes one LSB.
    function automatic longint fx_div(longint a, longint b);
        longint d;
        d = (b == 0) ? 64'sd1 : b;
        return sat32((a * ONE) / d);
    endfunction

    // Physical flux of one side, plus the star correction when the face is subsonic.
    task automatic side_flux(input longint st[7], input longint nrm[3], input longint ws,
                             input longint smid, input bit star, output longint res[5]);
        longint vn, ksq, eng, etot, rel, drho, dvn, rstar, estar, ms;
        longint mom[3];
        vn = 0;
        ksq = 0;
        mom = '{0, 0, 0};
        for (int i = 0; i < DIM; i++) begin
            vn = fx_add(vn, fx_mul(st[1+i], nrm[i]));
            ksq = fx_add(ksq, fx_mul(st[1+i], st[1+i]));
            mom[i] = fx_mul(st[0], st[1+i]);
        end
        eng = fx_add(st[4], ksq >>> 1);
        etot = fx_mul(st[0], eng);
        res[0] = fx_mul(st[0], vn);
        res[1] = 0;
        res[2] = 0;
        res[3] = 0;
        for (int i = 0; i < DIM; i++) begin
            res[1+i] = fx_add(fx_mul(vn, mom[i]), fx_mul(st[5], nrm[i]));
        end
        res[4] = fx_mul(vn, fx_add(etot, st[5]));
        if (star) begin
            rel = fx_sub(ws, vn);
            drho = fx_mul(st[0], rel);
            dvn = fx_sub(smid, vn);
            rstar = fx_div(drho, fx_sub(ws, smid));
            estar = fx_mul(rstar, fx_add(eng, fx_mul(dvn, fx_add(smid, fx_div(st[5], drho)))));
            res[0] = fx_add(res[0], fx_mul(ws, fx_sub(rstar, st[0])));
            for (int i = 0; i < DIM; i++) begin
                ms = fx_mul(rstar, fx_add(st[1+i], fx_mul(nrm[i], dvn)));
                res[1+i] = fx_add(res[1+i], fx_mul(ws, fx_sub(ms, mom[i])));
            end
            res[4] = fx_add(res[4], fx_mul(ws, fx_sub(estar, etot)));
        end
    endtask

    task automatic predict_face(input face_item_t it);
        longint rs[7], ls[7], nrm[3], res[5];
        longint vnl, vnr, wl, wr, al, ar, num, den, smid;
        flux_t fl;
        for (int i = 0; i < 7; i++) rs[i] = it.v[i];
        if (!it.side) begin
            left_held = rs;
            return;
        end
        ls = left_held;
        for (int i = 0; i < 3; i++) nrm[i] = it.v[7+i];
        vnl = 0;
        vnr = 0;
        for (int i = 0; i < DIM; i++) begin
            vnl = fx_add(vnl, fx_mul(ls[1+i], nrm[i]));
            vnr = fx_add(vnr, fx_mul(rs[1+i], nrm[i]));
        end
        wl = fx_sub(vnl, ls[6]);
        if (fx_sub(vnr, rs[6]) < wl) wl = fx_sub(vnr, rs[6]);
        wr = fx_add(vnl, ls[6]);
        if (fx_add(vnr, rs[6]) > wr) wr = fx_add(vnr, rs[6]);
        al = fx_sub(wl, vnl);
        ar = fx_sub(wr, vnr);
        num = fx_sub(rs[5], ls[5]);
        num = fx_add(num, fx_mul(fx_mul(ls[0], vnl), al));
        num = fx_sub(num, fx_mul(fx_mul(rs[0], vnr), ar));
        den = fx_sub(fx_mul(ls[0], al), fx_mul(rs[0], ar));
        smid = fx_div(num, den);
        if (wl >= 0) side_flux(ls, nrm, wl, smid, 1'b0, res);
        else if (wr <= 0) side_flux(rs, nrm, wr, smid, 1'b0, res);
        else if (smid >= 0) side_flux(ls, nrm, wl, smid, 1'b1, res);
        else side_flux(rs, nrm, wr, smid, 1'b1, res);
        for (int i = 0; i < 5; i++) fl.f[i] = int'(res[i]);
        expected_fluxes.push_back(fl);
    endtask

    task automatic report(input string what, input int got, input int want);
        fail_count++;
        $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    task automatic add_face(input bit side, input int d, input int vx, input int vy,
                            input int vz, input int e, input int p, input int c,
                            input int nx, input int ny, input int nz);
        face_item_t it;
        it.side = side;
        it.v = '{d, vx, vy, vz, e, p, c, nx, ny, nz};
        pending_faces.push_back(it);
    endtask

    function automatic int rand_q(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int rand_sign(int x);
        return $urandom_range(1) ? -x : x;
    endfunction

    // A plausible gas state with a unit-ish normal.
    task automatic add_physical(input bit side);
        int nx, ny, nz;
        case ($urandom_range(3))
            0: begin nx = rand_sign(ONE); ny = 0; nz = 0; end
            1: begin nx = 0; ny = rand_sign(ONE); nz = 0; end
            2: begin nx = 0; ny = 0; nz = rand_sign(ONE); end
            default: begin
                nx = rand_sign(37837);
                ny = rand_sign(37837);
                nz = rand_sign(37837);
            end
        endcase
        add_face(side, rand_q(ONE / 4, 4 * ONE), rand_q(-4 * ONE, 4 * ONE),
                 rand_q(-4 * ONE, 4 * ONE), rand_q(-4 * ONE, 4 * ONE),
                 rand_q(0, 8 * ONE), rand_q(ONE / 8, 6 * ONE), rand_q(ONE / 4, 3 * ONE),
                 nx, ny, nz);
    endtask

    task automatic add_noise();
        add_face($urandom_range(1), $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic add_random_faces(input int count);
        int n;
        n = 0;
        while (n < count) begin
            if ($urandom_range(99) < 85) begin
                add_physical(1'b0);
                add_physical(1'b1);
                n += 2;
            end else begin
                add_noise();
                n++;
            end
        end
    endtask

    task automatic drain_phase();
        while (pending_faces.size() != 0 || s_valid || expected_fluxes.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Driver: a new transaction is offered only once the previous one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                predict_face(cur_face);
            end
            if (pending_faces.size() != 0 && $urandom_range(99) >= send_idle) begin
                cur_face = pending_faces.pop_front();
                s_valid <= 1'b1;
                s_side <= cur_face.side;
                s_density <= cur_face.v[0];
                s_vel_x <= cur_face.v[1];
                s_vel_y <= cur_face.v[2];
                s_vel_z <= cur_face.v[3];
                s_internal_energy <= cur_face.v[4];
                s_pressure <= cur_face.v[5];
                s_sound_speed <= cur_face.v[6];
                s_normal_x <= cur_face.v[7];
                s_normal_y <= cur_face.v[8];
                s_normal_z <= cur_face.v[9];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: each result transaction is checked against the oldest predicted flux.
    always @(posedge aclk) begin
        flux_t want;
        int got[5];
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
            if (m_valid && m_ready) begin
                got = '{m_mass_flux, m_mom_flux_x, m_mom_flux_y, m_mom_flux_z, m_energy_flux};
                if (expected_fluxes.size() == 0) begin
                    report("unexpected flux", got[0], 0);
                end else begin
                    want = expected_fluxes.pop_front();
                    if (got[0] != want.f[0]) report("mass_flux", got[0], want.f[0]);
                    if (got[1] != want.f[1]) report("mom_flux_x", got[1], want.f[1]);
                    if (got[2] != want.f[2]) report("mom_flux_y", got[2], want.f[2]);
                    if (got[3] != want.f[3]) report("mom_flux_z", got[3], want.f[3]);
                    if (got[4] != want.f[4]) report("energy_flux", got[4], want.f[4]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < 7; i++) left_held[i] = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Right state before any left state: the cleared left state is used.
        add_face(1, 0, 0, 0, 0, 0, 0, 0, ONE, 0, 0);
        add_face(1, ONE, ONE, 0, 0, ONE, ONE, ONE, ONE, 0, 0);
        // Field extremes, saturating everywhere.
        add_face(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
        add_face(1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        add_face(0, 0, 0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        add_face(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        // Zero states on both sides: the contact denominator hits the guard.
        add_face(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_face(1, 0, 0, 0, 0, 0, 0, 0, ONE, 0, 0);
        // Supersonic to the right, then to the left.
        add_face(0, ONE, 5 * ONE, 0, 0, ONE, ONE, ONE, 0, 0, 0);
        add_face(1, ONE, 5 * ONE, ONE, 0, ONE, ONE, ONE, ONE, 0, 0);
        add_face(0, ONE, -5 * ONE, 0, 0, ONE, ONE, ONE, 0, 0, 0);
        add_face(1, ONE, -5 * ONE, 0, ONE, ONE, ONE, ONE, ONE, 0, 0);
        // Subsonic with the contact moving right, then left.
        add_face(0, 2 * ONE, ONE / 2, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE, 0, 0, 0);
        add_face(1, ONE, ONE / 2, ONE, 0, ONE, ONE, 2 * ONE, ONE, 0, 0);
        add_face(0, ONE, -ONE / 2, 0, 0, ONE, ONE, 2 * ONE, 0, 0, 0);
        add_face(1, 2 * ONE, -ONE / 2, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE, ONE, 0, 0);
        // Other normal directions.
        add_face(0, ONE, ONE, 2 * ONE, -ONE, ONE, ONE, ONE, 0, 0, 0);
        add_face(1, ONE, -ONE, ONE, ONE, ONE, 2 * ONE, ONE, 0, ONE, 0);
        add_face(1, ONE, -ONE, ONE, ONE, ONE, 2 * ONE, ONE, 0, 0, -ONE);
        add_face(1, ONE, ONE, ONE, ONE, ONE, ONE, ONE, -ONE, 0, 0);
        add_random_faces(220);
        drain_phase();

        @(negedge aclk);
        send_idle = 82;
        recv_idle = 26;
        add_random_faces(240);
        drain_phase();

        @(negedge aclk);
        send_idle = 0;
        recv_idle = 0;
        add_random_faces(240);
        drain_phase();

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== hllc_riemann_flux_unit.f =====
src/hrf_pkg.sv
src/hrf_ram.sv
src/hrf_div.sv
src/hrf_datapath.sv
src/hrf_ctrl.sv
src/hllc_riemann_flux_unit.sv
tb/sv/tb_hllc_riemann_flux_unit.sv
